// File: sv/kmh_pkg.sv
`timescale 1ns / 1ps

package kmh_pkg;

    // Field widths of the item channels
    localparam int KEY_W  = 48;
    localparam int ID_W   = 10;
    localparam int SLOT_W = 10;

    // Action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Input item
    typedef struct packed {
        logic              action;
        logic [ID_W-1:0]   first_index;
        logic [ID_W-1:0]   second_index;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
    } t_in;

    // Result item
    typedef struct packed {
        logic [ID_W-1:0]  out_first_index;
        logic [ID_W-1:0]  out_second_index;
        logic [KEY_W-1:0] out_key;
    } t_out;

    // One heap entry as stored
    typedef struct packed {
        logic [ID_W-1:0]  first_id;
        logic [ID_W-1:0]  second_id;
        logic [KEY_W-1:0] key;
    } t_entry;

    localparam int     ENT_W     = $bits(t_entry);
    localparam t_entry ENT_EMPTY = '1;

    // Child selection for one sift level
    typedef struct packed {
        logic   take_right;
        logic   stop;
        t_entry child;
    } t_pick;

endpackage

// File: sv/kmh_ram.sv
`timescale 1ns / 1ps

module kmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Write one word, register one read word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;

endmodule

// File: sv/kmh_pick.sv
`timescale 1ns / 1ps

module kmh_pick (
    input  kmh_pkg::t_entry i_ent,
    input  kmh_pkg::t_entry i_left,
    input  kmh_pkg::t_entry i_right,
    input  logic            i_right_ok,
    output kmh_pkg::t_pick  o_pick
);
    import kmh_pkg::*;

    logic w_take_right;

    // Take the larger child, the right one on a tie; the left one when there is no right child
    assign w_take_right = i_right_ok && !(i_left.key > i_right.key);

    always_comb begin
        o_pick.take_right = w_take_right;
        o_pick.child      = w_take_right ? i_right : i_left;
        // Stop once the sifted entry is not below the chosen child
        o_pick.stop       = !(i_ent.key < o_pick.child.key);
    end

endmodule

// File: sv/k_smallest_max_heap.sv
`timescale 1ns / 1ps

// Bounded max-heap that keeps the CAPACITY smallest-keyed entries pushed.
// Input channel: i_in_valid / o_in_stall / i_in_data. A push (action 0)
// replaces the root when its key is below the root key, then sifts it down;
// it gives no result. A read (action 1) returns the entry at one heap slot,
// the empty entry (all ones) for a slot at or beyond CAPACITY.
// Output channel: o_out_valid / i_out_stall / o_out_data, one result per read.
// Slot 0 sits in a register; left children live in one RAM and right
// children in another, so both children of a level come back in one read.
// A dropped push leaves the sequencer idle; a kept push walks the sift
// state once per level, reading both children from the RAMs, plus at most
// one final write, then returns to idle.
// A read passes through the read wait state to its result, then the
// sequencer is idle again. Reset starts a clearing pass that writes both RAMs
// to all ones; no item is taken during it.
// A stalled result is held in the output register; pushes keep flowing,
// and a new read waits until the held result is transferred.
module k_smallest_max_heap #(
    parameter int CAPACITY = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  kmh_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output kmh_pkg::t_out o_out_data
);
    import kmh_pkg::*;

    localparam int HALF       = CAPACITY / 2;
    localparam int HW         = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int SW         = $clog2(CAPACITY);
    localparam int SLOT_EXT_W = 17;

    // Sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SIFT   = 3'd2;
    localparam logic [2:0] ST_FINAL  = 3'd3;
    localparam logic [2:0] ST_RDWAIT = 3'd4;

    // Source of a read result
    localparam logic [1:0] RD_ROOT  = 2'd0;
    localparam logic [1:0] RD_LEFT  = 2'd1;
    localparam logic [1:0] RD_RIGHT = 2'd2;
    localparam logic [1:0] RD_EMPTY = 2'd3;

    logic [2:0]    r_state, n_state;
    t_entry        r_ent, n_ent;
    logic [SW-1:0] r_pos, n_pos;
    t_entry        r_root, n_root;
    logic [HW-1:0] r_clr, n_clr;
    logic [1:0]    r_rd_kind, n_rd_kind;
    logic          r_out_valid, n_out_valid;
    t_out          r_out, n_out;

    logic             w_acc;
    logic [HW-1:0]    w_rd_idx;
    logic [HW-1:0]    w_wr_idx;
    logic [ENT_W-1:0] w_wr_data;
    logic             w_wr_go;
    logic             w_l_we, w_r_we, w_bank_we;
    logic [ENT_W-1:0] w_l_q, w_r_q;
    t_pick            w_pick;
    t_entry           w_sel;

    logic [SW+1:0] w_left_slot, w_right_slot, w_pick_slot, w_grand_slot;
    logic          w_right_ok, w_grand_ok;
    logic [SW-1:0] w_pos_m1, w_pos_sh;

    logic [SLOT_EXT_W-1:0] w_slot_ext, w_slot_m1, w_slot_sh;
    logic                  w_slot_ok;

    // Accept only when idle; a read also needs a free output register
    assign o_in_stall = (r_state != ST_IDLE) ||
                        ((i_in_data.action == ACT_READ) && r_out_valid && i_out_stall);
    assign w_acc      = i_in_valid && !o_in_stall;

    // Child slots of the current position
    assign w_left_slot  = (SW + 2)'({r_pos, 1'b1});
    assign w_right_slot = (SW + 2)'({r_pos, 1'b0}) + (SW + 2)'(2);
    assign w_right_ok   = w_right_slot < (SW + 2)'(CAPACITY);
    assign w_pick_slot  = w_pick.take_right ? w_right_slot : w_left_slot;
    assign w_grand_slot = (SW + 2)'({w_pick_slot[SW-1:0], 1'b1});
    assign w_grand_ok   = w_grand_slot < (SW + 2)'(CAPACITY);

    // Bank index of the current position
    assign w_pos_m1 = r_pos - SW'(1);
    assign w_pos_sh = w_pos_m1 >> 1;

    // Bank index and range of a read slot
    assign w_slot_ext = SLOT_EXT_W'(i_in_data.slot);
    assign w_slot_ok  = w_slot_ext < SLOT_EXT_W'(CAPACITY);
    assign w_slot_m1  = w_slot_ext - SLOT_EXT_W'(1);
    assign w_slot_sh  = w_slot_m1 >> 1;

    kmh_ram #(
        .WIDTH (ENT_W),
        .DEPTH (HALF)
    ) u_left_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_l_we),
        .i_wr_addr (w_wr_idx),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_idx),
        .o_rd_data (w_l_q)
    );

    kmh_ram #(
        .WIDTH (ENT_W),
        .DEPTH (HALF)
    ) u_right_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_r_we),
        .i_wr_addr (w_wr_idx),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_idx),
        .o_rd_data (w_r_q)
    );

    kmh_pick u_pick (
        .i_ent      (r_ent),
        .i_left     (t_entry'(w_l_q)),
        .i_right    (t_entry'(w_r_q)),
        .i_right_ok (w_right_ok),
        .o_pick     (w_pick)
    );

    // Pick the stored entry for a read result
    always_comb begin
        case (r_rd_kind)
            RD_ROOT:  w_sel = r_root;
            RD_LEFT:  w_sel = t_entry'(w_l_q);
            RD_RIGHT: w_sel = t_entry'(w_r_q);
            default:  w_sel = ENT_EMPTY;
        endcase
    end

    // Sequencer and write-back
    always_comb begin
        n_state     = r_state;
        n_ent       = r_ent;
        n_pos       = r_pos;
        n_root      = r_root;
        n_clr       = r_clr;
        n_rd_kind   = r_rd_kind;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_rd_idx    = '0;
        w_wr_idx    = w_pos_sh[HW-1:0];
        w_wr_data   = r_ent;
        w_wr_go     = 1'b0;
        w_bank_we   = 1'b0;

        // Drop the held result once transferred
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                w_bank_we = 1'b1;
                w_wr_idx  = r_clr;
                w_wr_data = ENT_EMPTY;
                n_clr     = r_clr + HW'(1);
                if (r_clr == HW'(HALF - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_in_data.action == ACT_PUSH) begin
                        if (i_in_data.key < r_root.key) begin
                            n_ent.first_id  = i_in_data.first_index;
                            n_ent.second_id = i_in_data.second_index;
                            n_ent.key       = i_in_data.key;
                            n_pos           = '0;
                            w_rd_idx        = '0;
                            n_state         = ST_SIFT;
                        end
                    end else begin
                        w_rd_idx = w_slot_sh[HW-1:0];
                        if (!w_slot_ok) begin
                            n_rd_kind = RD_EMPTY;
                        end else if (i_in_data.slot == '0) begin
                            n_rd_kind = RD_ROOT;
                        end else if (i_in_data.slot[0]) begin
                            n_rd_kind = RD_LEFT;
                        end else begin
                            n_rd_kind = RD_RIGHT;
                        end
                        n_state = ST_RDWAIT;
                    end
                end
            end
            ST_SIFT: begin
                w_rd_idx = w_pick_slot[HW-1:0];
                w_wr_go  = 1'b1;
                if (w_pick.stop) begin
                    n_state = ST_IDLE;
                end else begin
                    // Move the larger child up and descend
                    w_wr_data = w_pick.child;
                    n_pos     = w_pick_slot[SW-1:0];
                    if (!w_grand_ok) begin
                        n_state = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                w_wr_go = 1'b1;
                n_state = ST_IDLE;
            end
            ST_RDWAIT: begin
                n_out.out_first_index  = w_sel.first_id;
                n_out.out_second_index = w_sel.second_id;
                n_out.out_key          = w_sel.key;
                n_out_valid            = 1'b1;
                n_state                = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Route a write at the current position to the root or a bank
        w_l_we = w_bank_we;
        w_r_we = w_bank_we;
        if (w_wr_go) begin
            if (r_pos == '0) begin
                n_root = t_entry'(w_wr_data);
            end else if (r_pos[0]) begin
                w_l_we = 1'b1;
            end else begin
                w_r_we = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_root      <= ENT_EMPTY;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_root      <= n_root;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ent     <= n_ent;
        r_pos     <= n_pos;
        r_rd_kind <= n_rd_kind;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A result appears only after the read wait cycle
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_RDWAIT)
        else $error("result appeared without a read");

    // The output register is free while a read result is on its way
    a_rd_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RDWAIT |-> !r_out_valid)
        else $error("read result would overwrite a held result");

    // Sifting only at a position with a left child
    a_sift_has_child: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SIFT |-> w_left_slot < (SW + 2)'(CAPACITY))
        else $error("sift position has no child");

endmodule

// File: verif/k_smallest_max_heap_tb.sv
`timescale 1ns / 1ps

module k_smallest_max_heap_tb;

    import kmh_pkg::*;

    localparam int HEAP_CAP      = 1024;
    localparam int QUIET_LIMIT   = 5000;
    localparam int LONG_HOLD     = 200;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE_ITEMS   = 240;
    localparam int RESET_CYCLES  = 5;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    // Mirror of the heap store and the reads still owed by the block
    t_entry heap_mirror [HEAP_CAP];
    t_out   expected_reads [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_on        = 1'b0;
    int hold_count     = 0;
    int quiet_cycles   = 0;
    int errors         = 0;

    k_smallest_max_heap #(
        .CAPACITY(HEAP_CAP)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one accepted item to the mirror; queue the answer of a read
    function automatic void heap_apply(input t_in item);
        int unsigned pos;
        int unsigned lc;
        int unsigned rc;
        int unsigned pick;
        t_entry      tmp;
        t_out        res;
        if (item.action == ACT_PUSH) begin
            if (!(item.key < heap_mirror[0].key))
                return;
            heap_mirror[0] = '{first_id: item.first_index, second_id: item.second_index,
                               key: item.key};
            pos = 0;
            // Sift the new root down toward the larger child, right child on a tie
            while (2 * pos + 1 < HEAP_CAP) begin
                lc = 2 * pos + 1;
                rc = lc + 1;
                if (rc >= HEAP_CAP)
                    pick = lc;
                else
                    pick = (heap_mirror[lc].key > heap_mirror[rc].key) ? lc : rc;
                if (heap_mirror[pos].key >= heap_mirror[pick].key)
                    break;
                tmp               = heap_mirror[pos];
                heap_mirror[pos]  = heap_mirror[pick];
                heap_mirror[pick] = tmp;
                pos               = pick;
            end
        end else begin
            tmp = (item.slot < HEAP_CAP) ? heap_mirror[item.slot] : ENT_EMPTY;
            res.out_first_index  = tmp.first_id;
            res.out_second_index = tmp.second_id;
            res.out_key          = tmp.key;
            expected_reads.push_back(res);
        end
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: k = {16'($urandom()), $urandom()};
            // narrow range to force equal keys among children
            5, 6:          k = KEY_W'($urandom_range(7));
            // equal to the root: dropped
            7:             k = heap_mirror[0].key;
            8:             k = heap_mirror[0].key - 1'b1;
            default:       k = '1;
        endcase
        return k;
    endfunction

    function automatic t_in make_push(input logic [ID_W-1:0] fid, input logic [ID_W-1:0] sid,
                                      input logic [KEY_W-1:0] k);
        t_in item;
        item.action       = ACT_PUSH;
        item.first_index  = fid;
        item.second_index = sid;
        item.key          = k;
        item.slot         = SLOT_W'($urandom());
        return item;
    endfunction

    function automatic t_in make_read(input logic [SLOT_W-1:0] s);
        t_in item;
        item.action       = ACT_READ;
        item.first_index  = ID_W'($urandom());
        item.second_index = ID_W'($urandom());
        item.key          = {16'($urandom()), $urandom()};
        item.slot         = s;
        return item;
    endfunction

    function automatic t_in random_item();
        logic [SLOT_W-1:0] s;
        s = ($urandom_range(3) == 0) ? SLOT_W'($urandom_range(14)) : SLOT_W'($urandom());
        if ($urandom_range(99) < 18)
            return make_read(s);
        return make_push(ID_W'($urandom()), ID_W'($urandom()), random_key());
    endfunction

    // Offer one item, hold it until the transfer, then update the mirror
    task automatic send_item(input t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        heap_apply(item);
    endtask

    task automatic test_empty_heap();
        send_item(make_read(SLOT_W'(0)));
        send_item(make_read(SLOT_W'(511)));
        send_item(make_read(SLOT_W'(HEAP_CAP - 1)));
    endtask

    task automatic test_push_edge_cases();
        send_item(make_push('0, '0, '1));
        send_item(make_read(SLOT_W'(0)));
        send_item(make_push('1, '1, '0));
        send_item(make_read(SLOT_W'(0)));
        send_item(make_read(SLOT_W'(HEAP_CAP - 2)));
        send_item(make_push(ID_W'(10'h155), ID_W'(10'h2AA), {KEY_W{1'b1}} - 1'b1));
        send_item(make_push(ID_W'(5), ID_W'(6), '0));
        send_item(make_push(ID_W'(7), ID_W'(8), '0));
        send_item(make_push(ID_W'(9), ID_W'(3), KEY_W'(1)));
        send_item(make_read(SLOT_W'(0)));
        send_item(make_read(SLOT_W'(1)));
        send_item(make_read(SLOT_W'(2)));
        send_item(make_read(SLOT_W'(HEAP_CAP - 3)));
        send_item(make_read(SLOT_W'(HEAP_CAP - 5)));
        send_item(make_read(SLOT_W'(HEAP_CAP - 1)));
    endtask

    // Hold the output for a long stretch while reads and pushes keep coming
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_on        = 1'b1;
        for (int i = 0; i < 16; i++) begin
            if (i % 2 == 0)
                send_item(make_read(SLOT_W'($urandom_range(6))));
            else
                send_item(make_push(ID_W'($urandom()), ID_W'($urandom()), random_key()));
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (PHASE_ITEMS)
            send_item(random_item());
    endtask

    // Drive the output stall: one long hold when asked, else random
    always @(posedge clk) begin
        if (hold_on && hold_count < LONG_HOLD) begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each result transfer with the oldest owed read
    always @(posedge clk) begin : check_results
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_reads.size() == 0) begin
                $display("%0t: result with none owed: expected nothing, actual %h",
                         $time, out_data);
                errors++;
            end else begin
                want = expected_reads.pop_front();
                if (out_data.out_first_index != want.out_first_index) begin
                    $display("%0t: out_first_index expected %0d actual %0d",
                             $time, want.out_first_index, out_data.out_first_index);
                    errors++;
                end
                if (out_data.out_second_index != want.out_second_index) begin
                    $display("%0t: out_second_index expected %0d actual %0d",
                             $time, want.out_second_index, out_data.out_second_index);
                    errors++;
                end
                if (out_data.out_key != want.out_key) begin
                    $display("%0t: out_key expected %h actual %h",
                             $time, want.out_key, out_data.out_key);
                    errors++;
                end
            end
        end
    end

    // Count cycles with no transfer on either side
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        foreach (heap_mirror[i])
            heap_mirror[i] = ENT_EMPTY;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_heap();
        test_push_edge_cases();
        test_output_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(77, 0);
        test_random_traffic(0, 77);
        test_random_traffic(27, 27);
        in_valid <= 1'b0;

        // Drain owed reads, then allow the last sift to settle
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0 && expected_reads.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
sv/kmh_pkg.sv
sv/kmh_ram.sv
sv/kmh_pick.sv
sv/k_smallest_max_heap.sv
verif/k_smallest_max_heap_tb.sv
